// File: hw/rtl/scr_pkg.sv
`default_nettype none
package scr_pkg;

    localparam int DefaultFracBits = 16;
    localparam int FricBits        = 16;
    localparam int FricWidth       = 18;
    localparam logic [FricWidth-1:0] FricReset = 18'd65536;

    localparam int DpWidth  = 32;
    localparam int MagWidth = 32;
    localparam int D2Width  = 66;
    localparam int RootWidth = 33;

    typedef enum logic [1:0] {
        OUT_NO_CONTACT = 2'd0,
        OUT_SEPARATING = 2'd1,
        OUT_IMPULSE    = 2'd2,
        OUT_COINCIDENT = 2'd3
    } outcome_t;

    typedef struct packed {
        logic signed [31:0] dpos_x;
        logic signed [31:0] dpos_y;
        logic signed [31:0] dpos_z;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_a_z;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic signed [31:0] vel_b_z;
        logic [30:0]        radius_sum;
    } pair_in_t;

    typedef struct packed {
        logic signed [31:0] new_vel_a_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_vel_a_z;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_b_y;
        logic signed [31:0] new_vel_b_z;
        logic [1:0]         outcome;
    } pair_out_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [2:0][31:0]   mag;
        logic [2:0]         neg;
        logic [2:0][31:0]   va;
        logic [2:0][31:0]   vb;
        logic [D2Width-1:0] d2;
        outcome_t           cls;
    } front_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/scr_front.sv
`default_nettype none
// Front: squared distance over pipelined multiplies and contact classification.
module scr_front
    import scr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pair_in_t    in_data,
    output logic             q_valid,
    input  wire logic        q_stall,
    output front_item_t      q_data
);
    localparam int Depth = 3;

    logic [Depth-1:0] vld_reg;
    logic             adv;

    // stage 0
    logic [2:0][31:0] mag_s0_reg, va_s0_reg, vb_s0_reg;
    logic [2:0]       neg_s0_reg;
    logic [30:0]      r_s0_reg;
    // stage 1
    logic [2:0][63:0] sq_s1_reg;
    logic [61:0]      r2_s1_reg;
    logic [2:0][31:0] mag_s1_reg, va_s1_reg, vb_s1_reg;
    logic [2:0]       neg_s1_reg;
    // stage 2
    front_item_t      item_reg;

    logic [2:0][31:0] mag_in;
    logic [2:0]       neg_in;
    logic [2:0][31:0] dp;
    logic [D2Width-1:0] d2;

    assign adv      = !(vld_reg[Depth-1] && q_stall);
    assign in_stall = !adv;
    assign q_valid  = vld_reg[Depth-1];
    assign q_data   = item_reg;

    always_comb
    begin
        dp = {in_data.dpos_z, in_data.dpos_y, in_data.dpos_x};
        for (int i = 0; i < 3; i++)
        begin
            neg_in[i] = dp[i][31];
            mag_in[i] = dp[i][31] ? 32'(-dp[i]) : dp[i];
        end
        d2 = D2Width'(sq_s1_reg[0]) + D2Width'(sq_s1_reg[1]) + D2Width'(sq_s1_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_s0_reg <= mag_in;
            neg_s0_reg <= neg_in;
            va_s0_reg  <= {in_data.vel_a_z, in_data.vel_a_y, in_data.vel_a_x};
            vb_s0_reg  <= {in_data.vel_b_z, in_data.vel_b_y, in_data.vel_b_x};
            r_s0_reg   <= in_data.radius_sum;
            for (int i = 0; i < 3; i++)
                sq_s1_reg[i] <= mag_s0_reg[i] * mag_s0_reg[i];
            r2_s1_reg  <= r_s0_reg * r_s0_reg;
            mag_s1_reg <= mag_s0_reg;
            neg_s1_reg <= neg_s0_reg;
            va_s1_reg  <= va_s0_reg;
            vb_s1_reg  <= vb_s0_reg;
            item_reg.mag <= mag_s1_reg;
            item_reg.neg <= neg_s1_reg;
            item_reg.va  <= va_s1_reg;
            item_reg.vb  <= vb_s1_reg;
            item_reg.d2  <= d2;
            if (d2 >= D2Width'(r2_s1_reg))
                item_reg.cls <= OUT_NO_CONTACT;
            else if (d2 == '0)
                item_reg.cls <= OUT_COINCIDENT;
            else
                item_reg.cls <= OUT_IMPULSE;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/scr_queue.sv
`default_nettype none
// Two-entry queue between front and back.
module scr_queue
    import scr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_valid,
    output logic             wr_stall,
    input  wire front_item_t wr_data,
    output logic             rd_valid,
    input  wire logic        rd_stall,
    output front_item_t      rd_data
);
    front_item_t mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// File: hw/rtl/scr_back.sv
`default_nettype none
// Back: pipelined square root, normal divides, projection and impulse.
module scr_back
    import scr_pkg::*;
#(
    parameter int FRAC_BITS = DefaultFracBits
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_stall,
    input  wire front_item_t          q_data,
    input  wire logic [FricWidth-1:0] fric,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pair_out_t                 out_data
);
    localparam int SqSteps  = RootWidth;          // one result bit a stage
    localparam int NumW     = MagWidth + FRAC_BITS;
    localparam int DivSteps = NumW;               // quotient bits
    // entry stage, root, divide entry stage, divide, six arithmetic stages
    localparam int Depth    = SqSteps + DivSteps + 8;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0][31:0] va;
        logic [2:0][31:0] vb;
        outcome_t         cls;
    } carry_t;

    logic [Depth-1:0] vld_reg;
    logic             adv;

    assign adv     = !(vld_reg[Depth-1] && out_stall);
    assign q_stall = !adv;
    assign out_valid = vld_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], q_valid};
    end

    // ---- square root: restoring, one bit per stage ----
    carry_t                 sq_c_reg   [SqSteps+1];
    logic [D2Width-1:0]     sq_rem_reg [SqSteps+1];
    logic [RootWidth-1:0]   sq_root_reg[SqSteps+1];
    logic [D2Width-1:0]     sq_d2_reg  [SqSteps+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_c_reg[0]    <= '{mag: q_data.mag, neg: q_data.neg, va: q_data.va,
                                vb: q_data.vb, cls: q_data.cls};
            sq_d2_reg[0]   <= q_data.d2;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < SqSteps; s++) begin : g_sqrt
        logic [D2Width+1:0] trial_rem;
        logic [D2Width+1:0] trial_sub;
        always_comb
        begin
            trial_rem = {sq_rem_reg[s], sq_d2_reg[s][D2Width-1 -: 2]};
            trial_sub = (D2Width+2)'({sq_root_reg[s], 2'b01});
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_c_reg[s+1]  <= sq_c_reg[s];
                sq_d2_reg[s+1] <= {sq_d2_reg[s][D2Width-3:0], 2'b00};
                if (trial_rem >= trial_sub)
                begin
                    sq_rem_reg[s+1]  <= D2Width'(trial_rem - trial_sub);
                    sq_root_reg[s+1] <= {sq_root_reg[s][RootWidth-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[s+1]  <= D2Width'(trial_rem);
                    sq_root_reg[s+1] <= {sq_root_reg[s][RootWidth-2:0], 1'b0};
                end
            end
        end
    end

    // ---- three restoring dividers: (|d| << FRAC_BITS) / dist ----
    carry_t               dv_c_reg   [DivSteps+1];
    logic [RootWidth-1:0] dv_den_reg [DivSteps+1];
    logic [2:0][NumW-1:0] dv_num_reg [DivSteps+1];
    logic [2:0][RootWidth:0] dv_rem_reg [DivSteps+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_c_reg[0]   <= sq_c_reg[SqSteps];
            dv_den_reg[0] <= (sq_root_reg[SqSteps] == '0) ? RootWidth'(1)
                                                           : sq_root_reg[SqSteps];
            for (int i = 0; i < 3; i++)
            begin
                dv_num_reg[0][i] <= {sq_c_reg[SqSteps].mag[i], FRAC_BITS'(0)};
                dv_rem_reg[0][i] <= '0;
            end
        end
    end

    for (genvar s = 0; s < DivSteps; s++) begin : g_div
        logic [2:0][RootWidth+1:0] tr;
        always_comb
        begin
            for (int i = 0; i < 3; i++)
                tr[i] = {dv_rem_reg[s][i], dv_num_reg[s][i][NumW-1]};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_c_reg[s+1]   <= dv_c_reg[s];
                dv_den_reg[s+1] <= dv_den_reg[s];
                for (int i = 0; i < 3; i++)
                begin
                    if (tr[i] >= (RootWidth+2)'(dv_den_reg[s]))
                    begin
                        dv_rem_reg[s+1][i] <= (RootWidth+1)'(tr[i] - (RootWidth+2)'(dv_den_reg[s]));
                        dv_num_reg[s+1][i] <= {dv_num_reg[s][i][NumW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[s+1][i] <= (RootWidth+1)'(tr[i]);
                        dv_num_reg[s+1][i] <= {dv_num_reg[s][i][NumW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---- projection, impulse, update ----
    // n magnitude stays below 2^(FRAC_BITS+1)+1, v difference within 33 bits.
    localparam int NW = FRAC_BITS + 2;
    carry_t                   p0_c_reg, p1_c_reg, p2_c_reg, p3_c_reg, p4_c_reg;
    carry_t                   p3_c_next;
    logic signed [2:0][NW-1:0] n0_reg, n1_reg, n2_reg, n3_reg, n4_reg;
    logic signed [2:0][32:0]  v0_reg;
    logic signed [2:0][33+NW-1:0] pr1_reg;
    logic signed [33+NW+1:0]  dot2_reg;
    logic [33+NW+1:0]         vm;
    logic [33+NW+1:0]         vm3_reg;
    logic [33+NW+FricWidth+1:0] jm;
    logic [33+NW+FricWidth+1:0] j4_reg;
    logic [2:0][NW-1:0]       nmag4;
    logic [2:0][33+NW+FricWidth+NW:0] dm;
    pair_out_t                res_reg;

    always_comb
    begin
        vm = dot2_reg[33+NW+1] ? (33+NW+2)'(-dot2_reg) : dot2_reg;
        vm = vm >> FRAC_BITS;
        jm = ((33+NW+FricWidth+2)'(vm3_reg) * (33+NW+FricWidth+2)'(fric)) >> FricBits;
        for (int i = 0; i < 3; i++)
        begin
            nmag4[i] = n4_reg[i][NW-1] ? NW'(-n4_reg[i]) : n4_reg[i];
            dm[i]    = ($bits(dm[i]))'(j4_reg) * ($bits(dm[i]))'(nmag4[i]);
            dm[i]    = dm[i] >> FRAC_BITS;
        end
        // a positive projection means the pair is separating
        p3_c_next = p2_c_reg;
        if (p2_c_reg.cls == OUT_IMPULSE && !dot2_reg[33+NW+1] && dot2_reg != '0)
            p3_c_next.cls = OUT_SEPARATING;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage A: signed normal and velocity difference
            p0_c_reg <= dv_c_reg[DivSteps];
            for (int i = 0; i < 3; i++)
            begin
                n0_reg[i] <= dv_c_reg[DivSteps].neg[i]
                           ? NW'(-dv_num_reg[DivSteps][i]) : NW'(dv_num_reg[DivSteps][i]);
                v0_reg[i] <= 33'(signed'(dv_c_reg[DivSteps].va[i]))
                           - 33'(signed'(dv_c_reg[DivSteps].vb[i]));
            end
            // stage B: products
            p1_c_reg <= p0_c_reg;
            n1_reg   <= n0_reg;
            for (int i = 0; i < 3; i++)
                pr1_reg[i] <= (33+NW)'($signed(v0_reg[i])) * (33+NW)'($signed(n0_reg[i]));
            // stage C: dot sum
            p2_c_reg <= p1_c_reg;
            n2_reg   <= n1_reg;
            dot2_reg <= (33+NW+2)'($signed(pr1_reg[0])) + (33+NW+2)'($signed(pr1_reg[1]))
                      + (33+NW+2)'($signed(pr1_reg[2]));
            // stage D: classify and magnitude
            p3_c_reg <= p3_c_next;
            n3_reg   <= n2_reg;
            vm3_reg  <= vm;
            // stage E: j magnitude (j is never positive)
            p4_c_reg <= p3_c_reg;
            n4_reg   <= n3_reg;
            j4_reg   <= jm;
            // stage F: delta and saturation; delta = -|j|*n
            res_reg.outcome <= p4_c_reg.cls;
            for (int i = 0; i < 3; i++)
            begin
                logic signed [65:0] dl;
                logic               dneg;
                dneg = !n4_reg[i][NW-1];
                dl = (p4_c_reg.cls != OUT_IMPULSE) ? 66'sd0
                   : dneg ? -$signed(66'(dm[i])) : $signed(66'(dm[i]));
                case (i)
                    0: begin
                        res_reg.new_vel_a_x <= sat32(66'(signed'(p4_c_reg.va[0])) - dl);
                        res_reg.new_vel_b_x <= sat32(66'(signed'(p4_c_reg.vb[0])) + dl);
                    end
                    1: begin
                        res_reg.new_vel_a_y <= sat32(66'(signed'(p4_c_reg.va[1])) - dl);
                        res_reg.new_vel_b_y <= sat32(66'(signed'(p4_c_reg.vb[1])) + dl);
                    end
                    default: begin
                        res_reg.new_vel_a_z <= sat32(66'(signed'(p4_c_reg.va[2])) - dl);
                        res_reg.new_vel_b_z <= sat32(66'(signed'(p4_c_reg.vb[2])) + dl);
                    end
                endcase
            end
        end
    end

    assign out_data = res_reg;
endmodule
`default_nettype wire

// File: hw/rtl/sphere_collision_response.sv
`default_nettype none
// Sphere pair collision impulse response.
// in_*: one candidate pair per transfer (valid/stall); out_*: one result per pair,
// in order. cfg_*: valid/ready write of friction_scale (unsigned Q2.16), taken
// whenever offered; write only while the block is idle.
// Throughput: one pair per cycle while the receiver does not stall. Path: 3 front
// stages, the queue, then an entry stage, 33 root stages, a divide entry stage,
// 32+FRAC_BITS divide stages and 6 arithmetic stages. Items may wait in the queue;
// most of the depth lies in the bit-serial root and divide pipelines.
// Reset clears all valid flags and returns friction_scale to 1.0.
// When the receiver stalls the back end holds; the queue absorbs the front
// end's items, then in_stall rises. Results never drop or repeat.
module sphere_collision_response
    import scr_pkg::*;
#(
    parameter int FRAC_BITS = DefaultFracBits
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pair_in_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pair_out_t                 out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [FricWidth-1:0] cfg_data
);
    logic [FricWidth-1:0] fric_reg;
    logic                 f_valid, f_stall, b_valid, b_stall;
    front_item_t          f_data, b_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fric_reg <= FricReset;
        else if (cfg_valid)
            fric_reg <= cfg_data;
    end

    scr_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
    );

    scr_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
    );

    scr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
        .fric(fric_reg), .out_valid, .out_stall, .out_data
    );
endmodule
`default_nettype wire

// File: hw/rtl/scr_checker.sv
`default_nettype none
module scr_checker
    import scr_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire pair_out_t out_data
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed under stall");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("unknown bits in result");
endmodule

bind sphere_collision_response scr_checker u_chk (
    .clk, .rst_n, .out_valid, .out_stall, .out_data
);
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import scr_pkg::*;

    localparam int FracBits = 16;
    localparam int Latency  = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pair_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pair_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [FricWidth-1:0] cfg_data = '0;

    logic [FricWidth-1:0] fric_model;
    pair_out_t response_q[$];
    int mismatches = 0;
    bit quiet_send = 1'b0;   // no random gaps from the sender
    bit quiet_recv = 1'b0;   // no random stalls from the receiver
    int hold_cycles = 0;     // long receiver hold-off still to run

    sphere_collision_response dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // a*b >> sh, truncated toward zero
    function automatic longint scaled_product(input longint a, input longint b, input int sh);
        logic [127:0] p;
        logic [63:0] ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic pair_out_t impulse_response(input pair_in_t p);
        pair_out_t r;
        longint d[3], va[3], vb[3], nrm[3], dlt[3];
        logic [63:0] d2, rr, root_d, q, m;
        longint dot, vdn, jmp;
        outcome_t oc;
        d = '{p.dpos_x, p.dpos_y, p.dpos_z};
        va = '{p.vel_a_x, p.vel_a_y, p.vel_a_z};
        vb = '{p.vel_b_x, p.vel_b_y, p.vel_b_z};
        dlt = '{0, 0, 0};
        d2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = d[i] < 0 ? -d[i] : d[i];
            d2 += m * m;
        end
        rr = 64'(p.radius_sum) * 64'(p.radius_sum);
        if (d2 >= rr)
            oc = OUT_NO_CONTACT;
        else if (d2 == 0)
            oc = OUT_COINCIDENT;
        else
        begin
            root_d = root_floor(d2);
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = d[i] < 0 ? -d[i] : d[i];
                q = (m << FracBits) / root_d;
                nrm[i] = d[i] < 0 ? -longint'(q) : longint'(q);
                dot += (va[i] - vb[i]) * nrm[i];
            end
            if (dot > 0)
                oc = OUT_SEPARATING;
            else
            begin
                vdn = -((-dot) >>> FracBits);
                jmp = scaled_product(vdn, longint'(fric_model), FricBits);
                for (int i = 0; i < 3; i++)
                    dlt[i] = scaled_product(jmp, nrm[i], FracBits);
                oc = OUT_IMPULSE;
            end
        end
        r.new_vel_a_x = clamp32(va[0] - dlt[0]);
        r.new_vel_a_y = clamp32(va[1] - dlt[1]);
        r.new_vel_a_z = clamp32(va[2] - dlt[2]);
        r.new_vel_b_x = clamp32(vb[0] + dlt[0]);
        r.new_vel_b_y = clamp32(vb[1] + dlt[1]);
        r.new_vel_b_z = clamp32(vb[2] + dlt[2]);
        r.outcome = oc;
        return r;
    endfunction

    // valid stays high after a transfer so that the next item can follow at once
    task automatic send_pair(input pair_in_t p);
        while (!quiet_send && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        response_q.push_back(impulse_response(p));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (response_q.size() != 0)
            @(negedge clk);
        repeat (Latency) @(negedge clk);
    endtask

    task automatic write_friction(input logic [FricWidth-1:0] v);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fric_model = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !quiet_recv && ($urandom_range(99) < 28);
    end

    always @(posedge clk)
    begin
        pair_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (response_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                want = response_q.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, out_data);
                end
            end
        end
    end

    function automatic logic signed [31:0] edge_word();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return -1;
            4: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // mostly touching pairs so that every outcome is reached
    function automatic pair_in_t random_pair();
        pair_in_t p;
        int sh;
        sh = $urandom_range(30, 8);
        p.dpos_x = $signed($urandom) >>> (32 - sh);
        p.dpos_y = $signed($urandom) >>> (32 - sh);
        p.dpos_z = $signed($urandom) >>> (32 - sh);
        p.vel_a_x = $urandom_range(9) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(12);
        p.vel_a_y = $urandom_range(9) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(12);
        p.vel_a_z = $urandom_range(9) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(12);
        p.vel_b_x = $urandom_range(9) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(12);
        p.vel_b_y = $urandom_range(9) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(12);
        p.vel_b_z = $urandom_range(9) == 0 ? edge_word() : $signed($urandom) >>> $urandom_range(12);
        case ($urandom_range(9))
            0: p.radius_sum = $urandom;
            1: p.radius_sum = 0;
            2: p.radius_sum = 31'h7fffffff;
            3:
            begin
                p.dpos_x = edge_word();
                p.dpos_y = edge_word();
                p.dpos_z = edge_word();
                p.radius_sum = $urandom;
            end
            default: p.radius_sum = 31'(1 << sh) << 1;
        endcase
        if ($urandom_range(39) == 0)
            p.dpos_x = 0;
        if ($urandom_range(39) == 0)
        begin
            p.dpos_x = 0;
            p.dpos_y = 0;
            p.dpos_z = 0;
        end
        return p;
    endfunction

    task automatic test_directed();
        pair_in_t p;
        p = '0;
        send_pair(p);                           // zero radius, no contact
        p.radius_sum = 31'h7fffffff;
        send_pair(p);                           // coincident centres
        p.dpos_x = 32'sh00010000;
        p.vel_a_x = -32'sh00020000;
        send_pair(p);                           // approaching head-on
        p.vel_a_x = 32'sh00020000;
        send_pair(p);                           // separating
        p.vel_a_x = 0;
        p.vel_a_y = 32'sh00050000;
        send_pair(p);                           // zero projection
        p = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff};
        send_pair(p);
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff};
        send_pair(p);                           // extreme values, no contact
        p = '{32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 31'h7fffffff};
        send_pair(p);
        p = '{-1, 1, -1, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000,
              -1, 31'd2};
        send_pair(p);
        p = '{32'sh00030000, 32'sh00040000, 0, -32'sh00010000, -32'sh00010000, 0,
              0, 0, 0, 31'h00050000};
        send_pair(p);                           // distance equals radius
        p.radius_sum = 31'h00050001;
        send_pair(p);
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_pair(random_pair());
    endtask

    task automatic test_no_idle();
        quiet_send = 1'b1;
        quiet_recv = 1'b1;
        test_random(60);
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    task automatic test_backpressure();
        quiet_send = 1'b1;
        hold_cycles = 300;
        test_random(150);
        quiet_send = 1'b0;
        // pause until everything is back
        drain_pipe();
        test_random(20);
    endtask

    task automatic test_friction();
        logic [FricWidth-1:0] settings[4];
        settings = '{18'd0, 18'd131072, 18'd3, 18'd40000};
        foreach (settings[k])
        begin
            write_friction(settings[k]);
            test_directed();
            test_random(30);
        end
        write_friction(18'd65536);
    endtask

    initial
    begin
        fric_model = FricReset;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(60);
        test_no_idle();
        test_backpressure();
        test_friction();
        test_random(40);
        drain_pipe();
        if (mismatches == 0 && response_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
